FILE: design/dmad_pkg.sv
// ----------------------------------------------------------------------------
// dmad_pkg
// shared constants and types of the dual moving average decimator
// ----------------------------------------------------------------------------
package dmad_pkg;

    localparam int DATA_W         = 16;
    localparam int DSN_W          = 32;
    localparam int DEC_W          = 8;
    localparam int WINDOW_DEFAULT = 128;
    localparam int FIFO_DEPTH     = 8;

    localparam logic [DEC_W-1:0] DEC_RESET = 8'd6;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_DECIMATION = 1'b0,
        REG_UNUSED     = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [DATA_W-1:0] red_average;
        logic [DATA_W-1:0] ir_average;
        logic [DSN_W-1:0]  dataset_number;
    } t_result;

endpackage

FILE: design/dual_moving_average_decimator.sv
// ----------------------------------------------------------------------------
// dual_moving_average_decimator
// two-channel boxcar moving average over a sample ring, one averaged
// dataset every decimation-th sample pair
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  -----------------------------------
//  sample    in         i_valid / o_stall    i_red_sample, i_ir_sample
//  dataset   out        o_valid / i_stall    o_red_average, o_ir_average,
//                                            o_dataset_number
//  config    in         psel/penable/pready  paddr, pwdata, prdata (decimation)
//
//  one sample pair per cycle while o_stall is low; the beat that causes a dataset
//  passes in turn through ring read, sum update, reciprocal multiply, queue push
//  reset clears sums, ring position and counters; the ring is never swept,
//  entries not yet written since reset read as zero until the first wrap
//  o_stall rises only when the result queue and the datasets in flight
//  together fill its 8 entries, i.e. after the output side has stalled
//
module dual_moving_average_decimator #(
    parameter int WINDOW = dmad_pkg::WINDOW_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // sample channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [dmad_pkg::DATA_W-1:0]         i_red_sample,
    input  logic [dmad_pkg::DATA_W-1:0]         i_ir_sample,

    // dataset channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [dmad_pkg::DATA_W-1:0]         o_red_average,
    output logic [dmad_pkg::DATA_W-1:0]         o_ir_average,
    output logic [dmad_pkg::DSN_W-1:0]          o_dataset_number,

    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dmad_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [dmad_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [dmad_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import dmad_pkg::*;

    localparam int POS_W  = $clog2(WINDOW);
    localparam int SUM_W  = DATA_W + POS_W;
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int USED_W = CNT_W + 1;

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic             cfg_write;
    t_reg_idx         cfg_idx;
    logic [DEC_W-1:0] r_decimation;

    assign pready    = 1'b1;
    assign cfg_idx   = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decimation <= DEC_RESET;
        end else if (cfg_write && cfg_idx == REG_DECIMATION) begin
            r_decimation <= pwdata[DEC_W-1:0];
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_DECIMATION: prdata = APB_DATA_W'(r_decimation);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // stage 0: accept, issue ring read, decimation and dataset count
    // ------------------------------------------------------------------
    logic              in_beat;
    logic              emit;
    logic [DEC_W:0]    cnt_inc;
    logic [POS_W-1:0]  r_pos;
    logic              r_wrapped;
    logic [DEC_W-1:0]  r_dec_cnt;
    logic [DSN_W-1:0]  r_dsn;
    logic              last_pos;

    // credit count: datasets in flight plus those queued
    logic              r_v1, r_e1, r_v2, r_v3;
    logic [CNT_W-1:0]  q_count;
    logic [USED_W-1:0] used;

    assign used = USED_W'(r_v1 && r_e1) + USED_W'(r_v2) + USED_W'(r_v3)
                + USED_W'(q_count);
    assign o_stall = (used >= USED_W'(FIFO_DEPTH));
    assign in_beat = i_valid && !o_stall;

    assign cnt_inc  = {1'b0, r_dec_cnt} + 1'b1;
    // decimation of zero behaves like one through the unsigned compare
    assign emit     = (cnt_inc >= {1'b0, r_decimation});
    assign last_pos = (r_pos == POS_W'(WINDOW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_wrapped <= 1'b0;
            r_dec_cnt <= '0;
            r_dsn     <= '0;
        end else if (in_beat) begin
            r_pos     <= last_pos ? '0 : r_pos + 1'b1;
            r_wrapped <= r_wrapped || last_pos;
            r_dec_cnt <= emit ? '0 : cnt_inc[DEC_W-1:0];
            if (emit) begin
                r_dsn <= r_dsn + 1'b1;
            end
        end
    end

    // payload of the item entering the ring update
    logic [DATA_W-1:0] r_red1, r_ir1;
    logic [POS_W-1:0]  r_pos1;
    logic              r_old_ok1;
    logic [DSN_W-1:0]  r_dsn1, r_dsn2, r_dsn3;

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_red1    <= i_red_sample;
            r_ir1     <= i_ir_sample;
            r_pos1    <= r_pos;
            r_old_ok1 <= r_wrapped;
            r_dsn1    <= r_dsn;
        end
        r_dsn2 <= r_dsn1;
        r_dsn3 <= r_dsn2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_e1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= in_beat;
            r_e1 <= in_beat && emit;
            r_v2 <= r_v1 && r_e1;
            r_v3 <= r_v2;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: ring read-modify-write and running sums
    // consecutive items touch different entries, so no forwarding path
    // ------------------------------------------------------------------
    logic [2*DATA_W-1:0] ring_rdata;
    logic [DATA_W-1:0]   old_red, old_ir;
    logic [SUM_W-1:0]    r_red_sum, r_ir_sum;

    dmad_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_v1),
        .i_waddr (r_pos1),
        .i_wdata ({r_ir1, r_red1}),
        .i_raddr (r_pos),
        .o_rdata (ring_rdata)
    );

    // entries not written since reset stand for zero
    assign old_red = r_old_ok1 ? ring_rdata[DATA_W-1:0]        : '0;
    assign old_ir  = r_old_ok1 ? ring_rdata[2*DATA_W-1:DATA_W] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_sum <= '0;
            r_ir_sum  <= '0;
        end else if (r_v1) begin
            r_red_sum <= r_red_sum - SUM_W'(old_red) + SUM_W'(r_red1);
            r_ir_sum  <= r_ir_sum  - SUM_W'(old_ir)  + SUM_W'(r_ir1);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: rounded means by reciprocal multiply
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] red_mean, ir_mean;

    dmad_scale #(
        .WINDOW (WINDOW)
    ) u_scale_red (
        .i_clk  (i_clk),
        .i_en   (r_v2),
        .i_sum  (r_red_sum),
        .o_mean (red_mean)
    );

    dmad_scale #(
        .WINDOW (WINDOW)
    ) u_scale_ir (
        .i_clk  (i_clk),
        .i_en   (r_v2),
        .i_sum  (r_ir_sum),
        .o_mean (ir_mean)
    );

    // ------------------------------------------------------------------
    // stage 3: result queue toward the output channel
    // ------------------------------------------------------------------
    t_result push_data, head;
    logic    out_beat;

    assign push_data.red_average    = red_mean;
    assign push_data.ir_average     = ir_mean;
    assign push_data.dataset_number = r_dsn3;

    assign o_valid  = (q_count != '0);
    assign out_beat = o_valid && !i_stall;

    dmad_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_v3),
        .i_data  (push_data),
        .i_pop   (out_beat),
        .o_data  (head),
        .o_count (q_count)
    );

    assign o_red_average    = head.red_average;
    assign o_ir_average     = head.ir_average;
    assign o_dataset_number = head.dataset_number;

endmodule

FILE: design/dmad_ram.sv
// ----------------------------------------------------------------------------
// dmad_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module dmad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/dmad_scale.sv
// ----------------------------------------------------------------------------
// dmad_scale
// rounded division of a window sum by the window length
// ----------------------------------------------------------------------------
module dmad_scale #(
    parameter int WINDOW = dmad_pkg::WINDOW_DEFAULT
) (
    input  logic                                          i_clk,
    input  logic                                          i_en,
    input  logic [dmad_pkg::DATA_W+$clog2(WINDOW)-1:0]    i_sum,
    output logic [dmad_pkg::DATA_W-1:0]                   o_mean
);
    import dmad_pkg::*;

    // exact reciprocal: x < 2^NUM_W, shift NUM_W + LOG_W, multiplier rounded up
    localparam int LOG_W  = $clog2(WINDOW);
    localparam int NUM_W  = DATA_W + LOG_W;
    localparam int SHIFT  = NUM_W + LOG_W;
    localparam int MULT_W = NUM_W + 1;
    localparam int PROD_W = NUM_W + MULT_W;
    localparam logic [63:0] MULT_WIDE = ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1)
                                        / 64'(WINDOW);
    localparam logic [MULT_W-1:0] MULT = MULT_WIDE[MULT_W-1:0];
    localparam logic [NUM_W-1:0]  HALF = NUM_W'(WINDOW / 2);

    logic [NUM_W-1:0]  num;
    logic [PROD_W-1:0] r_prod;

    // sum + window/2 stays below window * 2^16
    assign num = i_sum + HALF;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(num) * PROD_W'(MULT);
        end
    end

    assign o_mean = r_prod[SHIFT +: DATA_W];

endmodule

FILE: design/dmad_fifo.sv
// ----------------------------------------------------------------------------
// dmad_fifo
// small result queue in front of the output channel
// ----------------------------------------------------------------------------
module dmad_fifo #(
    parameter int DEPTH = dmad_pkg::FIFO_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  dmad_pkg::t_result            i_data,
    input  logic                         i_pop,
    output dmad_pkg::t_result            o_data,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    import dmad_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] ptr);
        logic [AW-1:0] res;
        if (ptr == AW'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = ptr + 1'b1;
        end
        return res;
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

FILE: tb/sv/dmad_tb_pkg.sv
// ----------------------------------------------------------------------------
// dmad_tb_pkg
// running model of both sample rings and the dataset scoreboard
// ----------------------------------------------------------------------------
package dmad_tb_pkg;

    import dmad_pkg::*;

    localparam int RING_LEN    = WINDOW_DEFAULT;
    localparam int MAX_REPORTS = 30;

    class dataset_scoreboard;

        logic [DATA_W-1:0] red_ring [RING_LEN];
        logic [DATA_W-1:0] ir_ring  [RING_LEN];
        int unsigned       red_total;
        int unsigned       ir_total;
        int unsigned       ring_idx;
        int unsigned       since_last;
        logic [DEC_W-1:0]  decimation;
        logic [DSN_W-1:0]  dataset_seq;
        t_result           pending_datasets [$];
        int unsigned       mismatches;
        int unsigned       samples_seen;
        int unsigned       datasets_seen;

        function new();
            foreach (red_ring[k]) begin
                red_ring[k] = '0;
                ir_ring[k]  = '0;
            end
            red_total     = 0;
            ir_total      = 0;
            ring_idx      = 0;
            since_last    = 0;
            decimation    = DEC_RESET;
            dataset_seq   = '0;
            mismatches    = 0;
            samples_seen  = 0;
            datasets_seen = 0;
        endfunction

        function void set_decimation(logic [DEC_W-1:0] value);
            decimation = value;
        endfunction

        function int unsigned pending();
            return pending_datasets.size();
        endfunction

        // one accepted sample beat: ring update and, on the decimation tick, a dataset
        function void absorb_sample(logic [DATA_W-1:0] red, logic [DATA_W-1:0] ir);
            t_result want;
            red_total = red_total - red_ring[ring_idx] + red;
            ir_total  = ir_total - ir_ring[ring_idx] + ir;
            red_ring[ring_idx] = red;
            ir_ring[ring_idx]  = ir;
            ring_idx = (ring_idx + 1) % RING_LEN;
            samples_seen++;
            since_last++;
            // zero decimation acts as one; a lowered setting fires on the next beat
            if (since_last >= decimation) begin
                since_last = 0;
                want.red_average    = DATA_W'((red_total + RING_LEN / 2) / RING_LEN);
                want.ir_average     = DATA_W'((ir_total + RING_LEN / 2) / RING_LEN);
                want.dataset_number = dataset_seq;
                dataset_seq++;
                pending_datasets.push_back(want);
            end
        endfunction

        task report(string what, logic [DSN_W-1:0] got, logic [DSN_W-1:0] want);
            if (mismatches < MAX_REPORTS)
                $display("mismatch: %s got 0x%0h want 0x%0h after %0d datasets",
                         what, got, want, datasets_seen);
            mismatches++;
        endtask

        task check_dataset(t_result got);
            t_result want;
            if (pending_datasets.size() == 0) begin
                report("dataset beat with none due, number", got.dataset_number, '0);
                return;
            end
            want = pending_datasets.pop_front();
            if (got.red_average !== want.red_average)
                report("red_average", DSN_W'(got.red_average), DSN_W'(want.red_average));
            if (got.ir_average !== want.ir_average)
                report("ir_average", DSN_W'(got.ir_average), DSN_W'(want.ir_average));
            if (got.dataset_number !== want.dataset_number)
                report("dataset_number", got.dataset_number, want.dataset_number);
            datasets_seen++;
        endtask

        task check_register(logic [APB_DATA_W-1:0] got);
            if (got !== APB_DATA_W'(decimation))
                report("decimation readback", DSN_W'(got), DSN_W'(decimation));
        endtask

    endclass

endpackage

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives sample pairs into the dual moving average decimator, checks every
// dataset beat against a running ring model, and walks the decimation
// register through zero, one, mid values and full scale under three
// idle patterns on both channels
// ----------------------------------------------------------------------------
module tb_top;

    import dmad_pkg::*;
    import dmad_tb_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int DRAIN_CYCLES   = 8;
    localparam int ITEMS_PER_LEG  = 155;
    localparam int TIMEOUT_CYCLES = 200_000;

    typedef enum int {SHAPE_MIXED, SHAPE_FULL, SHAPE_ZERO} t_shape;

    // clock, reset and block inputs, all known from time zero
    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_valid      = 1'b0;
    logic [DATA_W-1:0]     i_red_sample = '0;
    logic [DATA_W-1:0]     i_ir_sample  = '0;
    logic                  i_stall      = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;

    logic                  o_stall;
    logic                  o_valid;
    logic [DATA_W-1:0]     o_red_average;
    logic [DATA_W-1:0]     o_ir_average;
    logic [DSN_W-1:0]      o_dataset_number;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // idle rates in percent, changed per phase by the stimulus
    int send_idle_pct = 37;
    int recv_idle_pct = 50;

    dataset_scoreboard sb;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    dual_moving_average_decimator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_red_sample     (i_red_sample),
        .i_ir_sample      (i_ir_sample),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_red_average    (o_red_average),
        .o_ir_average     (o_ir_average),
        .o_dataset_number (o_dataset_number),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // receiver side: random stall per cycle at the current rate
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // beat monitor: everything here sees pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.absorb_sample(i_red_sample, i_ir_sample);
            if (o_valid === 1'b1 && !i_stall)
                sb.check_dataset({o_red_average, o_ir_average, o_dataset_number});
        end
    end

    // one sample beat, with a random idle gap in front of it
    task automatic send_sample(input logic [DATA_W-1:0] red, input logic [DATA_W-1:0] ir);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_red_sample <= red;
        i_ir_sample  <= ir;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // stop sending until every due dataset is out, then cover the pipeline
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // setup phase, access phase, then the bus returns to idle
    task automatic reg_write(input t_reg_idx idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // only the decimation register holds state; the spare address is ignored
        if (idx == REG_DECIMATION)
            sb.set_decimation(value[DEC_W-1:0]);
        @(posedge i_clk);
    endtask

    task automatic reg_read(input t_reg_idx idx, output logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // write decimation from an idle block and read it back
    task automatic set_decimation(input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] readback;
        wait_drained();
        reg_write(REG_DECIMATION, value);
        reg_read(REG_DECIMATION, readback);
        sb.check_register(readback);
    endtask

    function automatic logic [DATA_W-1:0] pick_sample(t_shape shape);
        case (shape)
            SHAPE_FULL: return '1;
            SHAPE_ZERO: return '0;
            default: begin
                case ($urandom_range(0, 9))
                    0:       return '0;
                    1:       return '1;
                    2:       return DATA_W'($urandom_range(0, 15));
                    default: return DATA_W'($urandom());
                endcase
            end
        endcase
    endfunction

    initial begin : stimulus
        logic [APB_DATA_W-1:0] readback;
        logic [DEC_W-1:0]      dec_plan [6];
        t_shape                shape;
        int                    leg;

        sb = new();
        dec_plan[0] = 8'd1;
        dec_plan[1] = 8'd7;
        dec_plan[2] = 8'd255;
        dec_plan[3] = 8'd2;
        dec_plan[4] = DEC_W'($urandom_range(3, 40));
        dec_plan[5] = 8'd128;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register comes up at its reset value
        reg_read(REG_DECIMATION, readback);
        sb.check_register(readback);

        // field extremes and walking patterns at the reset decimation
        send_sample('0, '0);
        send_sample('1, '1);
        send_sample('1, '0);
        send_sample('0, '1);
        send_sample(16'hAAAA, 16'h5555);
        send_sample(16'h5555, 16'hAAAA);
        send_sample(16'h8000, 16'h0001);
        send_sample(16'h0001, 16'h8000);

        // zero decimation behaves as one: a dataset per beat
        set_decimation('0);
        repeat (4) send_sample(pick_sample(SHAPE_MIXED), pick_sample(SHAPE_MIXED));

        // spare register address must leave decimation alone
        wait_drained();
        reg_write(REG_UNUSED, 32'h0000_0055);
        reg_read(REG_DECIMATION, readback);
        sb.check_register(readback);

        // full-scale decimation, then lowered below the running count;
        // upper data bits are dropped and the count is kept across the write
        set_decimation(32'd255);
        repeat (5) send_sample(pick_sample(SHAPE_MIXED), pick_sample(SHAPE_MIXED));
        set_decimation(32'hFFFF_FF03);
        repeat (4) send_sample(pick_sample(SHAPE_MIXED), pick_sample(SHAPE_MIXED));

        // random legs: two decimation settings under each idle pattern
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 37;
                    recv_idle_pct = 50;
                end
                1: begin
                    send_idle_pct = 50;
                    recv_idle_pct = 37;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int sub = 0; sub < 2; sub++) begin
                leg = 2 * ph + sub;
                set_decimation(APB_DATA_W'(dec_plan[leg]));
                for (int n = 0; n < ITEMS_PER_LEG; n++) begin
                    // fill the whole ring at full scale, or flush it to zero,
                    // at the start of some legs so the sums hit both ends
                    if (n < RING_LEN + 2 && (leg == 0 || leg == 4))
                        shape = SHAPE_FULL;
                    else if (n < RING_LEN + 2 && leg == 3)
                        shape = SHAPE_ZERO;
                    else
                        shape = SHAPE_MIXED;
                    send_sample(pick_sample(shape), pick_sample(shape));
                    // occasional full drain mid-stream
                    if ($urandom_range(0, 99) == 0)
                        wait_drained();
                end
            end
        end

        wait_drained();

        $display("summary: %0d sample beats in, %0d dataset beats checked, %0d mismatches",
                 sb.samples_seen, sb.datasets_seen, sb.mismatches);
        $display("summary: decimation 0, 1, 2, 3, 7, 128, 255 and one random; full-scale %s",
                 "and zero rings; three idle patterns");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // hard stop if a handshake hangs
    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
design/dmad_pkg.sv
design/dmad_ram.sv
design/dmad_scale.sv
design/dmad_fifo.sv
design/dual_moving_average_decimator.sv
tb/sv/dmad_tb_pkg.sv
tb/sv/tb_top.sv
